>>> rtl/ffe_pkg.sv
// Package for the frame field extractor: item types and request codes.
`default_nettype none

package ffe_pkg;

  // Request codes carried in req_type
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Widest field the datapath can assemble, in bytes
  localparam int unsigned FIELD_BYTES_MAX = 8;

  typedef struct packed {
    logic       req_type;
    logic       new_frame;
    logic [7:0] byte_value;
    logic [7:0] field_offset;
    logic [3:0] field_length;
    logic       little_endian;
  } in_item_t;

  typedef struct packed {
    logic [63:0] field_value;
    logic        range_err;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/frame_field_extractor.sv
// Frame field extractor: frame byte store, range check and field assembly.
// Load items are taken one per cycle while no extract runs; the byte goes into the frame
// memory, but is dropped if the frame is full and the item starts no new frame.
// Extract items read each byte through the single read port, then hand the field over;
// out-of-range and zero-length fields skip the reads. A result may wait at the output
// while further load items are accepted. Reset empties the frame; memory contents are kept.
`default_nettype none

module frame_field_extractor
  import ffe_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH     = 256,
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int unsigned LW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned SW = (LW > 9) ? LW : 9;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Frame store
  logic [7:0] mem [FRAME_DEPTH];

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] flen_q, flen_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [3:0]    idx_q, idx_d;
  logic [3:0]    len_q, len_d;
  logic          little_q, little_d;
  logic          oor_q, oor_d;
  logic [63:0]   acc_q, acc_d;
  logic          rd_vld_q, rd_vld_d;
  logic [7:0]    rd_data_q;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] end_pos;
  logic          oor_now;
  logic [SW-1:0] start_sum;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Range check on the incoming extract
  assign end_pos = SW'(in_item_i.field_offset) + SW'(in_item_i.field_length);
  assign oor_now = (in_item_i.field_length > 4'(MAX_FIELD_BYTES)) ||
                   (end_pos > SW'(flen_q));
  // First byte to read: lowest position for big-endian, highest for little-endian
  assign start_sum = in_item_i.little_endian ? (end_pos - SW'(1))
                                             : SW'(in_item_i.field_offset);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    flen_d      = flen_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    len_d       = len_q;
    little_d    = little_q;
    oor_d       = oor_q;
    acc_d       = acc_q;
    rd_vld_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = flen_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.req_type == REQ_LOAD) begin
            if (in_item_i.new_frame) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              flen_d    = LW'(1);
            end else if (flen_q < LW'(FRAME_DEPTH)) begin
              mem_we = 1'b1;
              flen_d = flen_q + LW'(1);
            end
          end else begin
            acc_d    = '0;
            idx_d    = '0;
            little_d = in_item_i.little_endian;
            oor_d    = oor_now;
            addr_d   = start_sum[AW-1:0];
            len_d    = in_item_i.field_length;
            if (oor_now || (in_item_i.field_length == 4'd0)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_READ;
            end
          end
        end
      end

      ST_READ: begin
        // Absorb the byte read in the previous cycle
        if (rd_vld_q) begin
          acc_d = {acc_q[55:0], rd_data_q};
        end
        // Issue the next read
        if (idx_q < len_q) begin
          rd_vld_d = 1'b1;
          idx_d    = idx_q + 4'd1;
          addr_d   = little_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
        end else if (rd_vld_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.field_value = oor_q ? 64'd0 : acc_q;
          out_d.range_err   = oor_q;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_item_i.byte_value;
    end
    rd_data_q <= mem[addr_q];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flen_q      <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flen_q      <= flen_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    little_q <= little_d;
    oor_q    <= oor_d;
    acc_q    <= acc_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for frame_field_extractor: directed table, then random frames against a predictor.
`timescale 1ns / 100ps

module tb;
  import ffe_pkg::*;

  localparam int FRAME_BYTES = 256;
  localparam int ITEM_TARGET = 700;

  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  frame_field_extractor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // Directed stimulus row: the item, and a hand-written answer where one is given
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  // Predictor state: frame store and number of loaded bytes
  logic [7:0] frame_mem [FRAME_BYTES];
  int         frame_len;

  out_item_t  field_q[$];
  row_t       rows[$];
  int         fails     = 0;
  int         sent      = 0;
  int         loads     = 0;
  int         extracts  = 0;
  int         drops     = 0;
  int         checked   = 0;
  int         oor_seen  = 0;
  int         drained   = 0;
  out_item_t  head;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("%0t: timeout, %0d results still awaited", $time, field_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Predictor: update frame state for one item, work out the answer to an extract
  function automatic void apply_item(input in_item_t it, output bit has_res, output bit took,
                                     output out_item_t res);
    logic [63:0] acc;
    int          pos;
    res     = '0;
    has_res = 1'b0;
    took    = 1'b1;
    if (it.req_type == REQ_LOAD) begin
      if (it.new_frame) frame_len = 0;
      if (frame_len < FRAME_BYTES) begin
        frame_mem[frame_len] = it.byte_value;
        frame_len++;
      end else begin
        took = 1'b0;
      end
    end else begin
      has_res = 1'b1;
      if (it.field_length > FIELD_BYTES_MAX ||
          int'(it.field_offset) + int'(it.field_length) > frame_len) begin
        res.range_err = 1'b1;
      end else begin
        acc = '0;
        for (int i = 0; i < int'(it.field_length); i++) begin
          pos = it.little_endian ? int'(it.field_offset) + int'(it.field_length) - 1 - i
                                 : int'(it.field_offset) + i;
          acc = {acc[55:0], frame_mem[pos]};
        end
        res.field_value = acc;
      end
    end
  endfunction

  // Item builders; the fields the operation ignores carry junk
  function automatic in_item_t ld(input bit restart, input logic [7:0] b);
    in_item_t it;
    it               = '1;
    it.req_type      = REQ_LOAD;
    it.new_frame     = restart;
    it.byte_value    = b;
    return it;
  endfunction

  function automatic in_item_t ex(input logic [7:0] off, input logic [3:0] len, input bit le);
    in_item_t it;
    it               = '0;
    it.req_type      = REQ_EXTRACT;
    it.new_frame     = 1'b1;
    it.byte_value    = 8'h5A;
    it.field_offset  = off;
    it.field_length  = len;
    it.little_endian = le;
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input logic [63:0] v,
                                  input bit oor);
    row_t r;
    r.item           = it;
    r.typed          = typed;
    r.want.field_value = v;
    r.want.range_err = oor;
    rows.push_back(r);
  endfunction

  function automatic in_item_t rand_load(input bit restart);
    in_item_t it;
    it           = in_item_t'($urandom());
    it.req_type  = REQ_LOAD;
    it.new_frame = restart;
    return it;
  endfunction

  // Mostly fields inside the frame, some just past the end, some fully random
  function automatic in_item_t rand_extract();
    in_item_t it;
    int       roll;
    int       len;
    int       hi;
    it          = in_item_t'($urandom());
    it.req_type = REQ_EXTRACT;
    roll        = $urandom_range(0, 9);
    if (roll < 8 && frame_len > 0) begin
      len = $urandom_range(0, (frame_len < 8) ? frame_len : 8);
      hi  = frame_len - len;
      if (hi > 255) hi = 255;
      it.field_length = 4'(len);
      it.field_offset = 8'($urandom_range(0, hi));
    end else if (roll == 8) begin
      len = $urandom_range(1, 8);
      hi  = frame_len - len + 1;
      if (hi < 0) hi = 0;
      if (hi > 255) hi = 255;
      it.field_length = 4'(len);
      it.field_offset = 8'(hi);
    end
    return it;
  endfunction

  // Present one item, wait for the handshake, then record what it should produce
  task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    bit        has_res;
    bit        took;
    out_item_t calc;
    gap = ((sent / 80) % 4 == 2) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    apply_item(it, has_res, took, calc);
    if (has_res) field_q.push_back(typed ? want : calc);
    if (it.req_type == REQ_LOAD) loads++;
    else extracts++;
    if (took) sent++;
    else drops++;
  endtask

  task automatic drive(input in_item_t it);
    offer(it, 1'b0, '0);
  endtask

  // Receiver: random hold-off per result, one long hold early on, some stall-free stretches
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (drained == 30) stall = 300;
      else if ((drained / 40) % 4 == 3) stall = 0;
      else stall = $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      drained++;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      if (field_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, got value %h err %b", $time,
                 out_item.field_value, out_item.range_err);
      end else begin
        head = field_q.pop_front();
        checked++;
        if (head.range_err) oor_seen++;
        if (out_item.field_value !== head.field_value) begin
          fails++;
          $display("%0t: field_value expected %h, got %h", $time, head.field_value,
                   out_item.field_value);
        end
        if (out_item.range_err !== head.range_err) begin
          fails++;
          $display("%0t: range_err expected %b, got %b", $time, head.range_err,
                   out_item.range_err);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int seq;
    int kind;
    int n;
    frame_len = 0;
    seq       = 0;

    // Empty frame, then an eight-byte frame covering both byte orders and the edges
    add_row(ex(8'd0, 4'd0, 1'b0), 1'b1, 64'h0, 1'b0);
    add_row(ex(8'd0, 4'd1, 1'b0), 1'b1, 64'h0, 1'b1);
    add_row(ex(8'd255, 4'd8, 1'b1), 1'b1, 64'h0, 1'b1);
    add_row(ex(8'd0, 4'd15, 1'b0), 1'b1, 64'h0, 1'b1);
    add_row(ld(1'b1, 8'h01), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'h23), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'h45), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'h67), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'h89), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'hAB), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'hCD), 1'b0, 64'h0, 1'b0);
    add_row(ld(1'b0, 8'hFF), 1'b0, 64'h0, 1'b0);
    add_row(ex(8'd0, 4'd8, 1'b0), 1'b1, 64'h0123456789ABCDFF, 1'b0);
    add_row(ex(8'd0, 4'd8, 1'b1), 1'b1, 64'hFFCDAB8967452301, 1'b0);
    add_row(ex(8'd4, 4'd4, 1'b0), 1'b1, 64'h89ABCDFF, 1'b0);   // float-sized word
    add_row(ex(8'd2, 4'd3, 1'b1), 1'b1, 64'h896745, 1'b0);
    add_row(ex(8'd8, 4'd0, 1'b0), 1'b1, 64'h0, 1'b0);          // zero length at the end
    add_row(ex(8'd9, 4'd0, 1'b0), 1'b1, 64'h0, 1'b1);
    add_row(ex(8'd7, 4'd2, 1'b0), 1'b1, 64'h0, 1'b1);          // one byte past the end
    add_row(ex(8'd7, 4'd1, 1'b1), 1'b1, 64'hFF, 1'b0);
    add_row(ld(1'b1, 8'h00), 1'b0, 64'h0, 1'b0);               // restart hides old bytes
    add_row(ex(8'd0, 4'd1, 1'b1), 1'b1, 64'h0, 1'b0);
    add_row(ex(8'd1, 4'd1, 1'b0), 1'b1, 64'h0, 1'b1);

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].want);

    // Random frames with extracts; one full frame with overflow bytes
    while (sent < ITEM_TARGET) begin
      seq++;
      if (seq == 4) begin
        drive(rand_load(1'b1));
        repeat (FRAME_BYTES + 2) drive(rand_load(1'b0));
        drive(ex(8'd248, 4'd8, 1'b0));
        drive(ex(8'd248, 4'd8, 1'b1));
        drive(ex(8'd255, 4'd1, 1'b0));
        drive(ex(8'd255, 4'd0, 1'b1));
        drive(ex(8'd255, 4'd2, 1'b0));
        drive(ex(8'd252, 4'd8, 1'b1));
        drive(ex(8'd100, 4'd9, 1'b0));                         // overlong inside the frame
        drive(ex(8'd0, 4'd15, 1'b1));
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          n = $urandom_range(1, 24);
          drive(rand_load(1'b1));
          repeat (n - 1) drive(rand_load(1'b0));
        end else if (kind == 7) begin
          n = $urandom_range(1, 8);
          repeat (n) drive(rand_load(1'b0));
        end else if (kind == 9) begin
          n = $urandom_range(1, 6);
          repeat (n) drive(in_item_t'($urandom()));
        end
        n = $urandom_range(2, 8);
        repeat (n) drive(rand_extract());
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for a late extra result
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d loads (%0d dropped on a full frame) and %0d extracts.",
             loads, drops, extracts);
    $display("Checked %0d results, %0d of them out of range.", checked, oor_seen);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ffe_pkg.sv
rtl/frame_field_extractor.sv
test/tb.sv
